// ===== rtl/wms_pkg.sv =====
`default_nettype none
package wms_pkg;

   localparam int STATE_FRAC_BITS = 16;
   localparam int VOLT_FRAC_BITS  = 12;
   localparam int RES_BITS        = 20;
   localparam int WINDOW_POWER    = 5;
   localparam int WIN_FRAC        = 30;
   localparam int CUR_FRAC        = 24;
   localparam int DT_FRAC         = 16;

   localparam int W_OFFSET   = ((2 ** STATE_FRAC_BITS) + 5000) / 10000;
   localparam int WIN_MULS   = 2 * WINDOW_POWER - 1;
   localparam int M_BITS     = RES_BITS + STATE_FRAC_BITS + 1;
   localparam int DVD_BITS   = 44;
   localparam int DIV_STEPS  = DVD_BITS;
   localparam int MUL_BITS   = 32;
   localparam int NANO_SCALE = 1000000000;

   localparam logic [2:0] CSR_ON_RES  = 3'd0;
   localparam logic [2:0] CSR_OFF_RES = 3'd1;
   localparam logic [2:0] CSR_STEP    = 3'd2;
   localparam logic [2:0] CSR_THRESH  = 3'd3;
   localparam logic [2:0] CSR_GAIN    = 3'd4;

   typedef struct packed {
      logic                  start;
      logic [DVD_BITS-1:0]   dividend;
      logic [M_BITS-1:0]     divisor;
   } div_req_type;

   typedef struct packed {
      logic                  busy;
      logic                  done;
      logic [DVD_BITS-1:0]   quotient;
   } div_rsp_type;

   typedef enum logic [19:0] {
      ST_IDLE   = 20'h00001,
      ST_MSPAN  = 20'h00002,
      ST_MDONE  = 20'h00004,
      ST_CSTART = 20'h00008,
      ST_DIVC   = 20'h00010,
      ST_THR    = 20'h00020,
      ST_THRC   = 20'h00040,
      ST_WIN    = 20'h00080,
      ST_WINC   = 20'h00100,
      ST_WDONE  = 20'h00200,
      ST_P2     = 20'h00400,
      ST_P3     = 20'h00800,
      ST_P3C    = 20'h01000,
      ST_T0     = 20'h02000,
      ST_T1     = 20'h04000,
      ST_T2     = 20'h08000,
      ST_UPD    = 20'h10000,
      ST_DSTART = 20'h20000,
      ST_DIVS   = 20'h40000,
      ST_DONE   = 20'h80000
   } seq_state_type;

endpackage
`default_nettype wire

// ===== rtl/wms_mul.sv =====
`default_nettype none
module wms_mul (
   input  wire logic                           clock,
   input  wire logic [wms_pkg::MUL_BITS-1:0]   mul_a,
   input  wire logic [wms_pkg::MUL_BITS-1:0]   mul_b,
   output logic      [2*wms_pkg::MUL_BITS-1:0] prod
);
   import wms_pkg::*;

   logic [2*MUL_BITS-1:0] prod_ff;
   logic [2*MUL_BITS-1:0] prod_in;

   // one registered product per cycle
   assign prod_in = (2*MUL_BITS)'(mul_a) * (2*MUL_BITS)'(mul_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule
`default_nettype wire

// ===== rtl/wms_div.sv =====
`default_nettype none
module wms_div (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire wms_pkg::div_req_type  div_req,
   output wms_pkg::div_rsp_type       div_rsp
);
   import wms_pkg::*;

   logic [M_BITS-1:0]   rem_ff, rem_in;
   logic [DVD_BITS-1:0] quo_ff, quo_in;
   logic [M_BITS-1:0]   dvs_ff, dvs_in;
   logic [5:0]          cnt_ff, cnt_in;
   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [M_BITS:0]     trial;
   logic                ge;

   // restoring division, one quotient bit a cycle
   assign trial = {rem_ff, quo_ff[DVD_BITS-1]};
   assign ge    = trial >= {1'b0, dvs_ff};

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (div_req.start) begin
         rem_in  = '0;
         quo_in  = div_req.dividend;
         dvs_in  = div_req.divisor;
         cnt_in  = 6'(DIV_STEPS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? M_BITS'(trial - {1'b0, dvs_ff}) : trial[M_BITS-1:0];
         quo_in = {quo_ff[DVD_BITS-2:0], ge};
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign div_rsp.busy     = busy_ff;
   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule
`default_nettype wire

// ===== rtl/windowed_memristor_state_step.sv =====
`default_nettype none
// channel | direction | handshake          | word
// req     | in        | req_valid/req_stall | decrease_voltage, increase_voltage
// rsp     | out       | rsp_valid/rsp_stall | next_state, memristance, device_voltage,
//         |           |                     | below_threshold
// csr     | in        | csr_valid/csr_ready | csr_index, csr_data
//
// one word at a time, from one req accept to the next: below threshold or with a degenerate
// range a word needs one 44-step divider pass for the current; otherwise it needs in addition
// a second pass for the new state and nine shared 32x32 multiplier passes for the window
// reset is synchronous: configuration registers back to defaults, device state cleared
// a finished word waits in the rsp register; the next req word is taken meanwhile
// and held in the final state until the rsp register is free
module windowed_memristor_state_step (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic signed [15:0] req_decrease_voltage,
   input  wire logic signed [15:0] req_increase_voltage,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [15:0]      rsp_next_state,
   output logic [19:0]      rsp_memristance,
   output logic signed [15:0] rsp_device_voltage,
   output logic             rsp_below_threshold,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [31:0] csr_data
);
   import wms_pkg::*;

   // configuration registers
   logic [RES_BITS-1:0] on_ff, off_ff;
   logic [15:0]         ts_ff;
   logic [19:0]         thr_ff;
   logic [31:0]         gain_ff;

   // sequencer and working registers
   seq_state_type         state_ff, state_in;
   logic [15:0]           dev_ff;
   logic signed [15:0]    v_ff;
   logic [15:0]           av_ff;
   logic [M_BITS-1:0]     m_ff, m_in;
   logic [27:0]           cur_ff;
   logic [31:0]           a30_ff, p_ff, p2_ff;
   logic [3:0]            cnt_ff;
   logic                  neg_ff;
   logic [43:0]           p3_ff;
   logic [47:0]           acc_ff;
   logic [M_BITS-1:0]     chg_ff;
   logic [15:0]           st_ff;
   logic                  below_ff;
   logic                  rsp_valid_ff;
   logic [15:0]           rsp_state_ff;
   logic [19:0]           rsp_mem_ff;
   logic signed [15:0]    rsp_volt_ff;
   logic                  rsp_below_ff;

   logic [MUL_BITS-1:0]   mul_a, mul_b;
   logic [2*MUL_BITS-1:0] prod;
   div_req_type           div_req;
   div_rsp_type           div_rsp;

   logic                  accept, load, span;
   logic [RES_BITS-1:0]   diff;
   logic [M_BITS-2:0]     lo, hi;
   logic signed [16:0]    vdiff;
   logic signed [15:0]    vsat;
   logic [16:0]           woff;
   logic signed [18:0]    xw;
   logic [16:0]           ax;
   logic signed [32:0]    win;
   logic [30:0]           aw;
   logic [63:0]           prnd, full;
   logic [55:0]           shr;
   logic signed [M_BITS+1:0] ms, mn;
   logic [M_BITS:0]       mrnd;

   assign accept    = req_valid && !req_stall;
   assign req_stall = state_ff != ST_IDLE;
   assign csr_ready = 1'b1;
   assign load      = (state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall);

   assign span = off_ff > on_ff;
   assign diff = off_ff - on_ff;
   assign lo   = {on_ff, {STATE_FRAC_BITS{1'b0}}};
   assign hi   = {off_ff, {STATE_FRAC_BITS{1'b0}}};

   // saturating voltage difference
   assign vdiff = 17'(req_increase_voltage) - 17'(req_decrease_voltage);
   always_comb begin
      priority if (vdiff > 17'sd32767)   vsat = 16'sh7fff;
      else if (vdiff < -17'sd32768)      vsat = 16'sh8000;
      else                               vsat = vdiff[15:0];
   end

   // window argument |2(w + offset) - 1| scaled to q2.30
   assign woff = {1'b0, dev_ff} + 17'(W_OFFSET);
   assign xw   = $signed({1'b0, woff, 1'b0}) - 19'sd65536;
   assign ax   = xw[18] ? 17'(-xw) : xw[16:0];

   assign win  = 33'sd1073741824 - $signed({1'b0, p_ff});
   assign aw   = win[32] ? 31'(-win) : win[30:0];

   assign prnd = prod + 64'(1 << (WIN_FRAC - 1));
   assign full = 64'(acc_ff) + {prod[31:0], 32'b0};
   assign shr  = full[63:8];

   // signed step of the memristance, clamped to the on/off range further down
   assign ms = $signed({2'b0, m_ff});
   assign mn = neg_ff ? ms - $signed({2'b0, chg_ff}) : ms + $signed({2'b0, chg_ff});

   assign mrnd = {1'b0, m_ff} + (M_BITS+1)'(1 << (STATE_FRAC_BITS - 1));

   // shared multiplier operand selection
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         ST_MSPAN: begin
            mul_a = 32'(diff);
            mul_b = 32'(dev_ff);
         end
         ST_THR: begin
            mul_a = 32'(cur_ff);
            mul_b = 32'(NANO_SCALE);
         end
         ST_WIN: begin
            mul_a = p_ff;
            mul_b = a30_ff;
         end
         ST_WDONE: begin
            mul_a = 32'(cur_ff);
            mul_b = 32'(aw);
         end
         ST_P3: begin
            mul_a = gain_ff;
            mul_b = p2_ff;
         end
         ST_T0: begin
            mul_a = p3_ff[31:0];
            mul_b = 32'(ts_ff);
         end
         ST_T1: begin
            mul_a = 32'(p3_ff[43:32]);
            mul_b = 32'(ts_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // divider requests
   always_comb begin
      div_req.start    = 1'b0;
      div_req.dividend = '0;
      div_req.divisor  = '0;
      if (state_ff == ST_CSTART) begin
         div_req.start    = 1'b1;
         div_req.dividend = {av_ff, 28'b0};
         div_req.divisor  = (m_ff < M_BITS'(1 << STATE_FRAC_BITS)) ?
                            M_BITS'(1 << STATE_FRAC_BITS) : m_ff;
      end else if (state_ff == ST_DSTART) begin
         div_req.start    = 1'b1;
         div_req.dividend = DVD_BITS'(m_ff - {1'b0, lo});
         div_req.divisor  = M_BITS'(diff);
      end
   end

   // clamp of the updated memristance
   always_comb begin
      priority if (mn < $signed({3'b0, lo}))  m_in = {1'b0, lo};
      else if (mn > $signed({3'b0, hi}))      m_in = {1'b0, hi};
      else                                    m_in = mn[M_BITS-1:0];
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (accept) state_in = ST_MSPAN;
         ST_MSPAN:  state_in = ST_MDONE;
         ST_MDONE:  state_in = ST_CSTART;
         ST_CSTART: state_in = ST_DIVC;
         ST_DIVC:   if (div_rsp.done) state_in = ST_THR;
         ST_THR:    state_in = ST_THRC;
         ST_THRC: begin
            priority if (prod < 64'({thr_ff, 24'b0})) state_in = ST_DONE;
            else if (!span)                           state_in = ST_DONE;
            else                                      state_in = ST_WIN;
         end
         ST_WIN:    state_in = ST_WINC;
         ST_WINC:   state_in = (cnt_ff == 4'(WIN_MULS - 1)) ? ST_WDONE : ST_WIN;
         ST_WDONE:  state_in = ST_P2;
         ST_P2:     state_in = ST_P3;
         ST_P3:     state_in = ST_P3C;
         ST_P3C:    state_in = ST_T0;
         ST_T0:     state_in = ST_T1;
         ST_T1:     state_in = ST_T2;
         ST_T2:     state_in = ST_UPD;
         ST_UPD:    state_in = ST_DSTART;
         ST_DSTART: state_in = ST_DIVS;
         ST_DIVS:   if (div_rsp.done) state_in = ST_DONE;
         ST_DONE:   if (load) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // control registers and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         dev_ff       <= '0;
         on_ff        <= 20'd100;
         off_ff       <= 20'd10000;
         ts_ff        <= 16'd655;
         thr_ff       <= 20'd10000;
         gain_ff      <= 32'd1000000;
      end else begin
         state_ff <= state_in;
         if (load) begin
            rsp_valid_ff <= 1'b1;
            dev_ff       <= st_ff;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_ON_RES:  on_ff   <= csr_data[RES_BITS-1:0];
               CSR_OFF_RES: off_ff  <= csr_data[RES_BITS-1:0];
               CSR_STEP:    ts_ff   <= csr_data[15:0];
               CSR_THRESH:  thr_ff  <= csr_data[19:0];
               CSR_GAIN:    gain_ff <= csr_data;
               default: begin
               end
            endcase
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (accept) begin
         v_ff  <= vsat;
         av_ff <= vsat[15] ? 16'(-17'(vsat)) : vsat;
      end
      if (state_ff == ST_MDONE)
         m_ff <= span ? {1'b0, lo} + prod[M_BITS-1:0] : {1'b0, lo};
      if (state_ff == ST_DIVC && div_rsp.done)
         cur_ff <= div_rsp.quotient[27:0];
      if (state_ff == ST_THRC) begin
         a30_ff <= 32'({ax, 14'b0});
         p_ff   <= 32'({ax, 14'b0});
         cnt_ff <= '0;
         priority if (prod < 64'({thr_ff, 24'b0})) begin
            below_ff <= 1'b1;
            st_ff    <= dev_ff;
         end else if (!span) begin
            below_ff <= 1'b0;
            st_ff    <= '0;
         end else begin
            below_ff <= 1'b0;
         end
      end
      if (state_ff == ST_WINC) begin
         p_ff   <= prnd[61:30];
         cnt_ff <= cnt_ff + 4'd1;
      end
      if (state_ff == ST_WDONE)
         neg_ff <= v_ff[15] ^ win[32];
      if (state_ff == ST_P2)
         p2_ff <= prod[61:30];
      if (state_ff == ST_P3C)
         p3_ff <= prod[59:16];
      if (state_ff == ST_T1)
         acc_ff <= prod[47:0];
      if (state_ff == ST_T2)
         chg_ff <= (shr > 56'(64'd1 << 36)) ? M_BITS'(64'd1 << 36) : shr[M_BITS-1:0];
      if (state_ff == ST_UPD)
         m_ff <= m_in;
      if (state_ff == ST_DIVS && div_rsp.done)
         st_ff <= (div_rsp.quotient > 44'hffff) ? 16'hffff : div_rsp.quotient[15:0];
      if (load) begin
         rsp_state_ff <= st_ff;
         rsp_mem_ff   <= mrnd[35:16];
         rsp_volt_ff  <= v_ff;
         rsp_below_ff <= below_ff;
      end
   end

   wms_mul u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .prod  (prod)
   );

   wms_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_next_state      = rsp_state_ff;
   assign rsp_memristance     = rsp_mem_ff;
   assign rsp_device_voltage  = rsp_volt_ff;
   assign rsp_below_threshold = rsp_below_ff;

   // divider only restarted once idle
   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> !div_rsp.busy) else $error("divider restarted while busy");

   // an accepted word starts the sequence
   a_start: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_MSPAN) else $error("sequencer did not start");

   // below threshold keeps the device state
   a_keep: assert property (@(posedge clock) disable iff (reset)
      (load && below_ff) |-> st_ff == dev_ff) else $error("state changed below threshold");

   // loaded word shows up on the output
   a_load: assert property (@(posedge clock) disable iff (reset)
      load |=> rsp_valid_ff && rsp_state_ff == $past(st_ff) && dev_ff == $past(st_ff))
      else $error("result word not presented");

endmodule
`default_nettype wire

// ===== test/windowed_memristor_state_step_tb.sv =====
`default_nettype none
module windowed_memristor_state_step_tb;
   import wms_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   // register index with no register behind it, writes must be dropped
   localparam logic [2:0] CSR_SPARE = 3'd5;

   typedef struct packed {
      logic signed [15:0] decrease_voltage;
      logic signed [15:0] increase_voltage;
   } volt_word_type;

   typedef struct packed {
      logic [15:0]        next_state;
      logic [19:0]        memristance;
      logic signed [15:0] device_voltage;
      logic               below_threshold;
   } step_word_type;

   logic clock, reset;
   logic req_valid, req_stall;
   logic signed [15:0] req_decrease_voltage, req_increase_voltage;
   logic rsp_valid, rsp_stall;
   logic [15:0] rsp_next_state;
   logic [19:0] rsp_memristance;
   logic signed [15:0] rsp_device_voltage;
   logic rsp_below_threshold;
   logic csr_valid, csr_ready;
   logic [2:0] csr_index;
   logic [31:0] csr_data;

   windowed_memristor_state_step u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_decrease_voltage(req_decrease_voltage),
      .req_increase_voltage(req_increase_voltage),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_next_state(rsp_next_state), .rsp_memristance(rsp_memristance),
      .rsp_device_voltage(rsp_device_voltage),
      .rsp_below_threshold(rsp_below_threshold),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   // shadow copy of the device registers and state
   logic [19:0] on_res, off_res, thresh_na;
   logic [15:0] dt_step;
   logic [31:0] gain;
   logic [15:0] dev_state;

   volt_word_type volt_words[$];      // words waiting to be offered
   step_word_type expected_steps[$];  // predicted rsp words, oldest first
   int  errors;
   bit  req_taken;                 // req word accepted at the last rising edge
   bit  quiet;                     // no idling on either side
   int  req_gap, rsp_gap;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("Simulation FAILED");
      $finish;
   end

   // one time step of the device, updates the shadow state
   function automatic step_word_type device_step(input volt_word_type vw);
      step_word_type r;
      longint v, lo, hi, m, x, win;
      logic [63:0] av, w, mdiv, cur, st, ax, a30, pw, aw, p2, p3, chg, span_res;
      bit span, below, neg;
      v = longint'(vw.increase_voltage) - longint'(vw.decrease_voltage);
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      av = (v < 0) ? 64'(-v) : 64'(v);
      w = 64'(dev_state);
      span = off_res > on_res;
      span_res = 64'(off_res) - 64'(on_res);
      lo = longint'(64'(on_res) << 16);
      hi = longint'(64'(off_res) << 16);
      m = span ? lo + longint'(span_res * w) : lo;
      // tiny resistance: at least one ohm for the division
      mdiv = 64'(m);
      if (mdiv < 64'd65536) mdiv = 64'd65536;
      cur = (av << 28) / mdiv;
      below = (cur * 64'd1000000000) < (64'(thresh_na) << 24);
      st = w;
      if (!below) begin
         // joglekar window 1 - x^10 in q2.30
         x = 2 * longint'(w + 64'(W_OFFSET)) - 65536;
         ax = (x < 0) ? 64'(-x) : 64'(x);
         a30 = ax << 14;
         pw = a30;
         for (int k = 1; k < 2 * WINDOW_POWER; k++)
            pw = (pw * a30 + (64'd1 << 29)) >> 30;
         win = (longint'(1) << 30) - longint'(pw);
         aw = (win < 0) ? 64'(-win) : 64'(win);
         p2 = (cur * aw) >> 30;
         p3 = (64'(gain) * p2) >> 16;
         chg = (p3 * 64'(dt_step)) >> 8;
         if (chg > (64'd1 << 36)) chg = 64'd1 << 36;
         neg = (v < 0) != (win < 0);
         if (span) begin
            m = neg ? m - longint'(chg) : m + longint'(chg);
            if (m < lo) m = lo;
            else if (m > hi) m = hi;
            st = 64'(m - lo) / span_res;
            if (st > 64'hffff) st = 64'hffff;
         end else begin
            st = '0;
         end
      end
      dev_state = st[15:0];
      r.next_state = dev_state;
      r.memristance = 20'((64'(m) + 64'd32768) >> 16);
      r.device_voltage = 16'(v);
      r.below_threshold = below;
      return r;
   endfunction

   // monitor: req acceptance drives the prediction, rsp words are checked
   always @(posedge clock) begin
      step_word_type got, want;
      req_taken = 1'b0;
      if (!reset && req_valid && !req_stall) begin
         expected_steps.push_back(device_step({req_decrease_voltage, req_increase_voltage}));
         req_taken = 1'b1;
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         got = {rsp_next_state, rsp_memristance, rsp_device_voltage, rsp_below_threshold};
         if (expected_steps.size() == 0) begin
            $error("rsp word with nothing expected");
            errors++;
         end else begin
            want = expected_steps.pop_front();
            if (got.next_state !== want.next_state) begin
               $error("next_state expected %0d actual %0d", want.next_state, got.next_state);
               errors++;
            end
            if (got.memristance !== want.memristance) begin
               $error("memristance expected %0d actual %0d",
                      want.memristance, got.memristance);
               errors++;
            end
            if (got.device_voltage !== want.device_voltage) begin
               $error("device_voltage expected %0d actual %0d",
                      want.device_voltage, got.device_voltage);
               errors++;
            end
            if (got.below_threshold !== want.below_threshold) begin
               $error("below_threshold expected %0b actual %0b",
                      want.below_threshold, got.below_threshold);
               errors++;
            end
         end
      end
   end

   // req driver: hold a word until taken, idle in random bursts
   always @(negedge clock) begin
      volt_word_type vw;
      if (!reset && !(req_valid && !req_taken)) begin
         if (req_gap > 0) begin
            req_gap--;
            req_valid <= 1'b0;
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            req_gap = $urandom_range(0, 9);
            req_valid <= 1'b0;
         end else if (volt_words.size() > 0) begin
            vw = volt_words.pop_front();
            req_valid <= 1'b1;
            req_decrease_voltage <= vw.decrease_voltage;
            req_increase_voltage <= vw.increase_voltage;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // rsp back-pressure in random bursts
   always @(negedge clock) begin
      if (rsp_gap > 0) begin
         rsp_gap--;
         rsp_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
         rsp_gap = $urandom_range(0, 9);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   task automatic csr_write(input logic [2:0] idx, input logic [31:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_ON_RES:  on_res    = data[19:0];
         CSR_OFF_RES: off_res   = data[19:0];
         CSR_STEP:    dt_step   = data[15:0];
         CSR_THRESH:  thresh_na = data[19:0];
         CSR_GAIN:    gain      = data;
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_device(input logic [19:0] ron, roff, thr,
                             input logic [15:0] dt, input logic [31:0] g);
      csr_write(CSR_ON_RES, 32'(ron));
      csr_write(CSR_OFF_RES, 32'(roff));
      csr_write(CSR_STEP, 32'(dt));
      csr_write(CSR_THRESH, 32'(thr));
      csr_write(CSR_GAIN, g);
   endtask

   // wait until every word has come back and the datapath has settled
   task automatic drain();
      while (volt_words.size() > 0 || expected_steps.size() > 0 || req_valid)
         @(posedge clock);
      repeat (150) @(posedge clock);
   endtask

   task automatic push_word(input logic [15:0] dec, input logic [15:0] inc);
      volt_words.push_back({dec, inc});
   endtask

   // random words: full range, small swings near the threshold, or zero
   task automatic push_random(input int count);
      int mode;
      for (int i = 0; i < count; i++) begin
         mode = $urandom_range(0, 9);
         if (mode < 5)
            push_word(16'($urandom), 16'($urandom));
         else if (mode < 9)
            push_word(16'(int'($urandom_range(0, 512)) - 256),
                      16'(int'($urandom_range(0, 512)) - 256));
         else
            push_word(16'h0000, 16'h0000);
      end
   endtask

   initial begin
      logic [19:0] ron;
      reset = 1'b1;
      req_valid = 1'b0;
      req_decrease_voltage = '0;
      req_increase_voltage = '0;
      rsp_stall = 1'b0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      errors = 0;
      req_gap = 0;
      rsp_gap = 0;
      quiet = 1'b0;
      req_taken = 1'b0;
      // reset defaults
      on_res = 20'd100;
      off_res = 20'd10000;
      dt_step = 16'd655;
      thresh_na = 20'd10000;
      gain = 32'd1000000;
      dev_state = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed words at default settings
      push_word(16'h0000, 16'h0000);   // no voltage, below threshold
      push_word(16'sh7fff, 16'sh8000); // difference saturates negative
      push_word(16'sh8000, 16'sh7fff); // difference saturates positive
      push_word(16'sh8000, 16'sh7fff); // drive state to full
      push_word(16'sh8000, 16'sh7fff);
      push_word(16'h0000, 16'sh7fff);
      push_word(16'h0000, 16'sh8000);
      push_word(16'sh7fff, 16'h0000);
      push_word(16'sh8000, 16'h0000);
      push_word(16'sh8000, 16'h0000);
      push_word(16'h0001, 16'h0000);
      push_word(16'h0000, 16'h0001);
      push_word(16'hffff, 16'hffff);
      push_word(16'h5555, 16'haaaa);
      push_word(16'haaaa, 16'h5555);
      push_word(16'h0000, 16'h0400);
      push_word(16'h0400, 16'h0000);
      push_word(16'h0000, 16'h1000);
      push_word(16'h1000, 16'h0000);
      push_word(16'h0000, 16'h0000);
      push_random(150);
      drain();

      // widest range, all extremes of the step registers
      set_device(20'd1, 20'hfffff, 20'd0, 16'hffff, 32'hffffffff);
      push_random(60);
      drain();

      // degenerate range, off below on
      set_device(20'hfffff, 20'd1, 20'd0, 16'd655, 32'd1000000);
      push_random(50);
      drain();

      // tiny resistance, on at zero; spare index must change nothing
      set_device(20'd0, 20'd50, 20'd1000, 16'd655, 32'd1000000);
      csr_write(CSR_SPARE, 32'hffffffff);
      push_random(50);
      drain();

      // no step length, no gain, threshold at its top
      set_device(20'd100, 20'd10000, 20'hfffff, 16'd0, 32'd0);
      push_random(50);
      drain();

      // random settings
      for (int ph = 0; ph < 4; ph++) begin
         ron = 20'($urandom_range(1, 5000));
         set_device(ron, ron + 20'($urandom_range(1, 200000)),
                    20'($urandom_range(0, 200000)), 16'($urandom),
                    $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 10000000));
         push_random(60);
         drain();
      end

      // back to defaults, no idling in the last stretch
      set_device(20'd100, 20'd10000, 20'd10000, 16'd655, 32'd1000000);
      quiet = 1'b1;
      push_random(50);
      drain();

      if (errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
`default_nettype wire
